// ----- rtl/core/ilfp_pkg.sv -----
// Shared types and constants for the chat-protocol line field parser.
// Holds the result and bundle types, parse stage codes and character codes.
// No dependencies.
package ilfp_pkg;

	localparam int MAX_TAGS        = 16;
	localparam int PARAM_LIMIT_MAX = 15;
	localparam int MAX_SPLITS      = 300;

	localparam int TAG_CNT_W = $clog2(MAX_TAGS + 1);
	localparam int PAR_CNT_W = $clog2(PARAM_LIMIT_MAX + 1);
	localparam int SPLIT_W   = $clog2(MAX_SPLITS);
	localparam int IDX_MAX_W = (TAG_CNT_W > PAR_CNT_W) ? TAG_CNT_W : PAR_CNT_W;
	localparam int IDX_W     = (IDX_MAX_W > 4) ? IDX_MAX_W : 4;

	localparam int RES_PER_ITEM = 3;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam int CFG_DATA_W = 5;

	typedef enum logic [0:0] {
		CFG_TAG_LIMIT   = 1'b0,
		CFG_PARAM_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_START    = 3'd0,
		ST_TAGS     = 3'd1,
		ST_HEAD     = 3'd2,
		ST_PREFIX   = 3'd3,
		ST_COMMAND  = 3'd4,
		ST_PARAMS   = 3'd5,
		ST_TRAILING = 3'd6,
		ST_SINK     = 3'd7
	} stage_t;

	localparam logic [2:0] KIND_TAG_KEY   = 3'd0;
	localparam logic [2:0] KIND_TAG_VALUE = 3'd1;
	localparam logic [2:0] KIND_PREFIX    = 3'd2;
	localparam logic [2:0] KIND_COMMAND   = 3'd3;
	localparam logic [2:0] KIND_MIDDLE    = 3'd4;
	localparam logic [2:0] KIND_TRAILING  = 3'd5;

	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_EMPTY        = 3'd1;
	localparam logic [2:0] STAT_TAGS_OPEN    = 3'd2;
	localparam logic [2:0] STAT_PREFIX_OPEN  = 3'd3;
	localparam logic [2:0] STAT_NO_COMMAND   = 3'd4;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LS    = 8'h73;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] index;
		logic [7:0] data;
		logic       valid;
		logic       opens;
		logic       done;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic [1:0]                     count;
		result_t [RES_PER_ITEM-1:0]     res;
	} bundle_t;

endpackage

// ----- rtl/core/ilfp_front.sv -----
// Front end of the line field parser: configuration registers and parse state.
// Classifies each accepted item into a bundle of up to three results.
// Depends on ilfp_pkg.
module ilfp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [ilfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          accept,
	input  logic [7:0]                    line_byte,
	input  logic                          byte_present,
	input  logic                          end_of_line,
	output logic                          push,
	output ilfp_pkg::bundle_t             bundle
);

	typedef struct packed {
		ilfp_pkg::stage_t                 stage;
		logic [ilfp_pkg::TAG_CNT_W-1:0]   tag_cnt;
		logic [ilfp_pkg::PAR_CNT_W-1:0]   par_cnt;
		logic [ilfp_pkg::SPLIT_W-1:0]     split_cnt;
		logic                             after;
		logic                             esc;
		logic                             in_val;
		logic                             started;
		logic                             kept;
		logic [ilfp_pkg::IDX_W-1:0]       cur_idx;
		logic                             out_open;
	} pstate_t;

	logic [4:0] tag_limit_q;
	logic [3:0] param_limit_q;
	pstate_t    st_q;
	pstate_t    st_d;

	function automatic ilfp_pkg::result_t mk(logic [2:0] kind, logic [ilfp_pkg::IDX_W-1:0] idx,
			logic [7:0] data, logic valid, logic opens, logic done, logic [2:0] status);
		ilfp_pkg::result_t r;
		r.kind   = kind;
		r.index  = idx[3:0];
		r.data   = data;
		r.valid  = valid;
		r.opens  = opens;
		r.done   = done;
		r.status = status;
		return r;
	endfunction

	function automatic logic tag_ok(logic [ilfp_pkg::TAG_CNT_W-1:0] cnt, logic [4:0] lim);
		return (32'(cnt) < 32'(lim)) && (32'(cnt) < ilfp_pkg::MAX_TAGS);
	endfunction

	function automatic logic par_ok(logic [ilfp_pkg::PAR_CNT_W-1:0] cnt, logic [3:0] lim);
		return (32'(cnt) < 32'(lim)) && (32'(cnt) < ilfp_pkg::PARAM_LIMIT_MAX);
	endfunction

	function automatic pstate_t tok_open(pstate_t s, logic [3:0] lim);
		pstate_t t;
		t = s;
		if (!t.started) begin
			t.started = 1'b1;
			t.kept    = par_ok(t.par_cnt, lim);
			if (t.kept) begin
				t.cur_idx = ilfp_pkg::IDX_W'(t.par_cnt);
				t.par_cnt = t.par_cnt + ilfp_pkg::PAR_CNT_W'(1);
			end
		end
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_limit_q   <= 5'd16;
			param_limit_q <= 4'd15;
		end else if (cfg_valid) begin
			case (ilfp_pkg::cfg_reg_t'(cfg_index))
				ilfp_pkg::CFG_TAG_LIMIT: begin
					tag_limit_q <= cfg_data[4:0];
				end
				ilfp_pkg::CFG_PARAM_LIMIT: begin
					param_limit_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		pstate_t           s;
		ilfp_pkg::bundle_t bd;
		logic [7:0]        b;
		logic [7:0]        c;
		logic [1:0]        n;
		logic              cmd;
		logic              em;
		logic              tend;
		logic              opens;
		logic [2:0]        em_kind;
		logic [2:0]        status;
		s       = st_q;
		bd      = '0;
		b       = line_byte;
		c       = line_byte;
		n       = 2'd0;
		cmd     = 1'b0;
		em      = 1'b0;
		tend    = 1'b0;
		opens   = 1'b0;
		em_kind = ilfp_pkg::KIND_TAG_KEY;
		status  = ilfp_pkg::STAT_OK;
		if (byte_present && b != 8'd0) begin
			case (s.stage)
				ilfp_pkg::ST_START: begin
					if (b == ilfp_pkg::CH_AT) begin
						s.stage   = ilfp_pkg::ST_TAGS;
						s.started = 1'b0;
					end else if (b == ilfp_pkg::CH_COLON) begin
						s.stage   = ilfp_pkg::ST_PREFIX;
						s.started = 1'b0;
					end else begin
						cmd = 1'b1;
					end
				end
				ilfp_pkg::ST_TAGS: begin
					if (b == ilfp_pkg::CH_SPACE || b == ilfp_pkg::CH_SEMI) begin
						tend = 1'b1;
						if (s.started && s.in_val && s.esc) begin
							em      = 1'b1;
							em_kind = ilfp_pkg::KIND_TAG_VALUE;
							c       = ilfp_pkg::CH_BSL;
						end
						if (b == ilfp_pkg::CH_SPACE) begin
							s.stage = ilfp_pkg::ST_HEAD;
						end
					end else begin
						if (!s.started) begin
							s.started  = 1'b1;
							s.out_open = 1'b0;
							s.kept     = tag_ok(s.tag_cnt, tag_limit_q);
							if (s.kept) begin
								s.cur_idx = ilfp_pkg::IDX_W'(s.tag_cnt);
								s.tag_cnt = s.tag_cnt + ilfp_pkg::TAG_CNT_W'(1);
							end
						end
						if (!s.in_val) begin
							if (b == ilfp_pkg::CH_EQ) begin
								s.in_val   = 1'b1;
								s.out_open = 1'b0;
							end else begin
								em = 1'b1;
							end
						end else if (s.esc) begin
							s.esc   = 1'b0;
							em      = 1'b1;
							em_kind = ilfp_pkg::KIND_TAG_VALUE;
							case (b)
								ilfp_pkg::CH_COLON: c = ilfp_pkg::CH_SEMI;
								ilfp_pkg::CH_LS:    c = ilfp_pkg::CH_SPACE;
								ilfp_pkg::CH_LR:    c = ilfp_pkg::CH_CR;
								ilfp_pkg::CH_LN:    c = ilfp_pkg::CH_LF;
								default:            c = b;
							endcase
						end else if (b == ilfp_pkg::CH_BSL) begin
							s.esc = 1'b1;
						end else begin
							em      = 1'b1;
							em_kind = ilfp_pkg::KIND_TAG_VALUE;
						end
					end
				end
				ilfp_pkg::ST_HEAD: begin
					if (b == ilfp_pkg::CH_COLON) begin
						s.stage   = ilfp_pkg::ST_PREFIX;
						s.started = 1'b0;
					end else begin
						cmd = 1'b1;
					end
				end
				ilfp_pkg::ST_PREFIX: begin
					if (b == ilfp_pkg::CH_SPACE) begin
						s.stage   = ilfp_pkg::ST_COMMAND;
						s.started = 1'b0;
					end else begin
						bd.res[n] = mk(ilfp_pkg::KIND_PREFIX, '0, b, 1'b1, !s.started, 1'b0,
							ilfp_pkg::STAT_OK);
						n = n + 2'd1;
						s.started = 1'b1;
					end
				end
				ilfp_pkg::ST_COMMAND: begin
					cmd = 1'b1;
				end
				ilfp_pkg::ST_PARAMS: begin
					if (s.after && b == ilfp_pkg::CH_COLON) begin
						s.after = 1'b0;
						s.stage = ilfp_pkg::ST_TRAILING;
						s.kept  = par_ok(s.par_cnt, param_limit_q);
						if (s.kept) begin
							s.cur_idx = ilfp_pkg::IDX_W'(s.par_cnt);
							s.par_cnt = s.par_cnt + ilfp_pkg::PAR_CNT_W'(1);
							bd.res[n] = mk(ilfp_pkg::KIND_TRAILING, s.cur_idx, 8'd0, 1'b0, 1'b1,
								1'b0, ilfp_pkg::STAT_OK);
							n = n + 2'd1;
						end
					end else begin
						if (s.after) begin
							s.after = 1'b0;
							if (32'(s.split_cnt) < ilfp_pkg::MAX_SPLITS - 1) begin
								s.split_cnt = s.split_cnt + ilfp_pkg::SPLIT_W'(1);
								s.started   = 1'b0;
							end else begin
								opens = !s.started;
								s     = tok_open(s, param_limit_q);
								if (s.kept) begin
									bd.res[n] = mk(ilfp_pkg::KIND_MIDDLE, s.cur_idx,
										ilfp_pkg::CH_SPACE, 1'b1, opens, 1'b0, ilfp_pkg::STAT_OK);
									n = n + 2'd1;
								end
							end
						end
						if (b == ilfp_pkg::CH_SPACE) begin
							s.after = 1'b1;
						end else begin
							opens = !s.started;
							s     = tok_open(s, param_limit_q);
							if (s.kept) begin
								bd.res[n] = mk(ilfp_pkg::KIND_MIDDLE, s.cur_idx, b, 1'b1, opens,
									1'b0, ilfp_pkg::STAT_OK);
								n = n + 2'd1;
							end
						end
					end
				end
				ilfp_pkg::ST_TRAILING: begin
					if (s.kept) begin
						bd.res[n] = mk(ilfp_pkg::KIND_TRAILING, s.cur_idx, b, 1'b1, 1'b0, 1'b0,
							ilfp_pkg::STAT_OK);
						n = n + 2'd1;
					end
				end
				default: begin
				end
			endcase
			if (em) begin
				if (s.kept) begin
					bd.res[n] = mk(em_kind, s.cur_idx, c, 1'b1, !s.out_open, 1'b0,
						ilfp_pkg::STAT_OK);
					n = n + 2'd1;
				end
				s.out_open = 1'b1;
			end
			if (tend) begin
				s.started  = 1'b0;
				s.in_val   = 1'b0;
				s.esc      = 1'b0;
				s.out_open = 1'b0;
			end
			if (cmd) begin
				if (b == ilfp_pkg::CH_SPACE) begin
					if (!s.started) begin
						s.stage = ilfp_pkg::ST_SINK;
					end else begin
						s.stage   = ilfp_pkg::ST_PARAMS;
						s.started = 1'b0;
						s.after   = 1'b1;
					end
				end else begin
					c = (b inside {[ilfp_pkg::CH_LA:ilfp_pkg::CH_LZ]}) ? b - ilfp_pkg::CASE_OFS : b;
					bd.res[n] = mk(ilfp_pkg::KIND_COMMAND, '0, c, 1'b1, !s.started, 1'b0,
						ilfp_pkg::STAT_OK);
					n = n + 2'd1;
					s.started = 1'b1;
					s.stage   = ilfp_pkg::ST_COMMAND;
				end
			end
		end
		if (end_of_line) begin
			case (s.stage)
				ilfp_pkg::ST_START:   status = ilfp_pkg::STAT_EMPTY;
				ilfp_pkg::ST_TAGS:    status = ilfp_pkg::STAT_TAGS_OPEN;
				ilfp_pkg::ST_HEAD:    status = ilfp_pkg::STAT_NO_COMMAND;
				ilfp_pkg::ST_PREFIX:  status = ilfp_pkg::STAT_PREFIX_OPEN;
				ilfp_pkg::ST_COMMAND: begin
					status = s.started ? ilfp_pkg::STAT_OK : ilfp_pkg::STAT_NO_COMMAND;
				end
				ilfp_pkg::ST_PARAMS: begin
					status = ilfp_pkg::STAT_OK;
					if (s.after) begin
						s.after = 1'b0;
						if (32'(s.split_cnt) < ilfp_pkg::MAX_SPLITS - 1) begin
							s.split_cnt = s.split_cnt + ilfp_pkg::SPLIT_W'(1);
							s.started   = 1'b0;
						end else begin
							opens = !s.started;
							s     = tok_open(s, param_limit_q);
							if (s.kept) begin
								bd.res[n] = mk(ilfp_pkg::KIND_MIDDLE, s.cur_idx,
									ilfp_pkg::CH_SPACE, 1'b1, opens, 1'b0, ilfp_pkg::STAT_OK);
								n = n + 2'd1;
							end
						end
					end
				end
				ilfp_pkg::ST_TRAILING: status = ilfp_pkg::STAT_OK;
				default:               status = ilfp_pkg::STAT_NO_COMMAND;
			endcase
			bd.res[n] = mk(ilfp_pkg::KIND_TAG_KEY, '0, 8'd0, 1'b0, 1'b0, 1'b1, status);
			n = n + 2'd1;
			s = '0;
		end
		bd.count = n;
		st_d     = s;
		bundle   = bd;
		push     = accept && (n != 2'd0);
	end

endmodule

// ----- rtl/core/ilfp_queue.sv -----
// Short queue of result bundles between the parser front and the serializer.
// Four entries of flip-flops with read and write pointers and a fill count.
// Depends on ilfp_pkg.
module ilfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ilfp_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output ilfp_pkg::bundle_t rd_data,
	output logic              empty
);

	ilfp_pkg::bundle_t             mem_q [ilfp_pkg::QDEPTH];
	logic [ilfp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ilfp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ilfp_pkg::QPTR_W:0]     cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full    = (cnt_q == (ilfp_pkg::QPTR_W + 1)'(ilfp_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + ilfp_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + ilfp_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (ilfp_pkg::QPTR_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (ilfp_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// ----- rtl/core/ilfp_back.sv -----
// Back end of the line field parser: hands out the results of the head bundle.
// One result per pop, then frees the bundle from the queue.
// Depends on ilfp_pkg.
module ilfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ilfp_pkg::bundle_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output ilfp_pkg::result_t res,
	output logic              empty
);

	logic [1:0] sub_q;
	logic       take;
	logic       last;

	assign empty = q_empty;
	assign take  = pop && !q_empty;
	assign last  = (sub_q == q_data.count - 2'd1);
	assign q_pop = take && last;

	always_comb begin
		case (sub_q)
			2'd1:    res = q_data.res[1];
			2'd2:    res = q_data.res[2];
			default: res = q_data.res[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 2'd0;
		end else if (take) begin
			sub_q <= last ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

// ----- rtl/core/irc_line_field_parser.sv -----
// Top level of the chat-protocol line field parser.
// Joins ilfp_front, ilfp_queue and ilfp_back; depends on ilfp_pkg.
//
//   channel   direction   handshake          payload
//   input     in          push / full        line_byte, byte_present, end_of_line
//   result    out         empty / pop        field_kind .. line_status
//   config    in          cfg_valid / ready  cfg_index, cfg_data
//
// The front takes one item per cycle while the four-bundle queue has room.
// The back hands out one result per cycle while pop is high, so an item with two or three
// results holds the back for one pop per result; the queue absorbs short bursts.
// Reset clears the line state and the queue and sets the limits to 16 and 15.
// A stalled result side fills the queue and then raises full.
module irc_line_field_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      line_byte,
	input  logic                            byte_present,
	input  logic                            end_of_line,
	output logic                            empty,
	input  logic                            pop,
	output logic [2:0]                      field_kind,
	output logic [3:0]                      field_index,
	output logic [7:0]                      out_byte,
	output logic                            byte_valid,
	output logic                            opens_field,
	output logic                            line_done,
	output logic [2:0]                      line_status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [ilfp_pkg::CFG_DATA_W-1:0] cfg_data
);

	ilfp_pkg::bundle_t wr_bundle;
	ilfp_pkg::bundle_t head;
	ilfp_pkg::result_t res;
	logic              accept;
	logic              wr_en;
	logic              q_empty;
	logic              q_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	ilfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.line_byte    (line_byte),
		.byte_present (byte_present),
		.end_of_line  (end_of_line),
		.push         (wr_en),
		.bundle       (wr_bundle)
	);

	ilfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_bundle),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	ilfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.res     (res),
		.empty   (empty)
	);

	assign field_kind  = res.kind;
	assign field_index = res.index;
	assign out_byte    = res.data;
	assign byte_valid  = res.valid;
	assign opens_field = res.opens;
	assign line_done   = res.done;
	assign line_status = res.status;

	a_full_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full with no result waiting");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> field_kind <= ilfp_pkg::KIND_TRAILING)
		else $error("result with unknown field kind");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_done) |-> (!byte_valid && !opens_field && out_byte == 8'd0))
		else $error("done result carries field data");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !line_done) |-> (line_status == ilfp_pkg::STAT_OK))
		else $error("status on a non-final result");

endmodule

// ----- sim/ilfp_checker.sv -----
`timescale 1ns / 1ps
// Checker for the chat-protocol line field parser: watches the input, result and
// register channels, predicts every field result and compares it with the block.
// Depends on ilfp_pkg for result type, stage, kind, status and character codes.
module ilfp_checker
	import ilfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   full,
	input  logic [7:0]             line_byte,
	input  logic                   byte_present,
	input  logic                   end_of_line,
	input  logic                   empty,
	input  logic                   pop,
	input  logic [2:0]             field_kind,
	input  logic [3:0]             field_index,
	input  logic [7:0]             out_byte,
	input  logic                   byte_valid,
	input  logic                   opens_field,
	input  logic                   line_done,
	input  logic [2:0]             line_status,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     fields_waiting
);

	logic [4:0] tag_limit;
	logic [3:0] param_limit;

	stage_t     stage;
	logic [4:0] tags_kept;
	logic [3:0] params_kept;
	logic [8:0] splits;
	logic       after_space;
	logic       escape_pending;
	logic       in_value;
	logic       field_open;
	logic       cur_kept;
	logic [3:0] cur_index;
	logic       out_open;

	result_t    parsed_fields[$];
	result_t    want;
	int         results_seen;

	task automatic report_error(string msg);
		if (fail_count < 40)
			$display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, int got, int wanted);
		if (got != wanted)
			report_error($sformatf("%s is %0d, should be %0d", name, got, wanted));
	endtask

	task automatic clear_line();
		stage          = ST_START;
		tags_kept      = '0;
		params_kept    = '0;
		splits         = '0;
		after_space    = 1'b0;
		escape_pending = 1'b0;
		in_value       = 1'b0;
		field_open     = 1'b0;
		cur_kept       = 1'b0;
		cur_index      = '0;
		out_open       = 1'b0;
	endtask

	task automatic queue_field(logic [2:0] kind, logic [3:0] idx, logic [7:0] data,
			logic valid, logic opens, logic done, logic [2:0] status);
		result_t r;
		r.kind   = kind;
		r.index  = idx;
		r.data   = data;
		r.valid  = valid;
		r.opens  = opens;
		r.done   = done;
		r.status = status;
		parsed_fields.push_back(r);
	endtask

	function automatic logic param_room();
		return params_kept < param_limit && params_kept < PARAM_LIMIT_MAX;
	endfunction

	task automatic tag_out(logic [2:0] kind, logic [7:0] b);
		if (cur_kept)
			queue_field(kind, cur_index, b, 1'b1, !out_open, 1'b0, STAT_OK);
		out_open = 1'b1;
	endtask

	// A backslash still pending when the tag closes is kept as itself.
	task automatic tag_close();
		if (field_open && in_value && escape_pending)
			tag_out(KIND_TAG_VALUE, CH_BSL);
		field_open     = 1'b0;
		in_value       = 1'b0;
		escape_pending = 1'b0;
		out_open       = 1'b0;
	endtask

	task automatic tag_char(logic [7:0] b);
		logic [7:0] c;
		if (b == CH_SPACE) begin
			tag_close();
			stage = ST_HEAD;
		end else if (b == CH_SEMI) begin
			tag_close();
		end else begin
			if (!field_open) begin
				field_open = 1'b1;
				out_open   = 1'b0;
				cur_kept   = tags_kept < tag_limit && tags_kept < MAX_TAGS;
				if (cur_kept) begin
					cur_index = tags_kept[3:0];
					tags_kept++;
				end
			end
			if (!in_value) begin
				if (b == CH_EQ) begin
					in_value = 1'b1;
					out_open = 1'b0;
				end else begin
					tag_out(KIND_TAG_KEY, b);
				end
			end else if (escape_pending) begin
				escape_pending = 1'b0;
				case (b)
					CH_COLON: c = CH_SEMI;
					CH_LS:    c = CH_SPACE;
					CH_LR:    c = CH_CR;
					CH_LN:    c = CH_LF;
					default:  c = b;
				endcase
				tag_out(KIND_TAG_VALUE, c);
			end else if (b == CH_BSL) begin
				escape_pending = 1'b1;
			end else begin
				tag_out(KIND_TAG_VALUE, b);
			end
		end
	endtask

	task automatic token_char(logic [7:0] b);
		logic opens;
		opens = 1'b0;
		if (!field_open) begin
			field_open = 1'b1;
			opens      = 1'b1;
			cur_kept   = param_room();
			if (cur_kept) begin
				cur_index = params_kept;
				params_kept++;
			end
		end
		if (cur_kept)
			queue_field(KIND_MIDDLE, cur_index, b, 1'b1, opens, 1'b0, STAT_OK);
	endtask

	// Once the split budget is spent, a space becomes a byte of the last token.
	task automatic split_space();
		after_space = 1'b0;
		if (splits < MAX_SPLITS - 1) begin
			splits++;
			field_open = 1'b0;
		end else begin
			token_char(CH_SPACE);
		end
	endtask

	task automatic command_char(logic [7:0] b);
		logic [7:0] c;
		c = b;
		if (b == CH_SPACE) begin
			if (!field_open) begin
				stage = ST_SINK;
			end else begin
				stage       = ST_PARAMS;
				field_open  = 1'b0;
				after_space = 1'b1;
			end
		end else begin
			if (b >= CH_LA && b <= CH_LZ)
				c = b - CASE_OFS;
			queue_field(KIND_COMMAND, '0, c, 1'b1, !field_open, 1'b0, STAT_OK);
			field_open = 1'b1;
			stage      = ST_COMMAND;
		end
	endtask

	task automatic param_char(logic [7:0] b);
		if (after_space && b == CH_COLON) begin
			after_space = 1'b0;
			stage       = ST_TRAILING;
			cur_kept    = param_room();
			if (cur_kept) begin
				cur_index = params_kept;
				params_kept++;
				queue_field(KIND_TRAILING, cur_index, '0, 1'b0, 1'b1, 1'b0, STAT_OK);
			end
		end else begin
			if (after_space)
				split_space();
			if (b == CH_SPACE)
				after_space = 1'b1;
			else
				token_char(b);
		end
	endtask

	task automatic parse_byte(logic [7:0] b);
		case (stage)
			ST_START: begin
				if (b == CH_AT) begin
					stage      = ST_TAGS;
					field_open = 1'b0;
				end else if (b == CH_COLON) begin
					stage      = ST_PREFIX;
					field_open = 1'b0;
				end else begin
					command_char(b);
				end
			end
			ST_TAGS: tag_char(b);
			ST_HEAD: begin
				if (b == CH_COLON) begin
					stage      = ST_PREFIX;
					field_open = 1'b0;
				end else begin
					command_char(b);
				end
			end
			ST_PREFIX: begin
				if (b == CH_SPACE) begin
					stage      = ST_COMMAND;
					field_open = 1'b0;
				end else begin
					queue_field(KIND_PREFIX, '0, b, 1'b1, !field_open, 1'b0, STAT_OK);
					field_open = 1'b1;
				end
			end
			ST_COMMAND: command_char(b);
			ST_PARAMS: param_char(b);
			ST_TRAILING: begin
				if (cur_kept)
					queue_field(KIND_TRAILING, cur_index, b, 1'b1, 1'b0, 1'b0, STAT_OK);
			end
			default: ;
		endcase
	endtask

	task automatic close_line();
		logic [2:0] status;
		case (stage)
			ST_START:    status = STAT_EMPTY;
			ST_TAGS:     status = STAT_TAGS_OPEN;
			ST_HEAD:     status = STAT_NO_COMMAND;
			ST_PREFIX:   status = STAT_PREFIX_OPEN;
			ST_COMMAND:  status = field_open ? STAT_OK : STAT_NO_COMMAND;
			ST_PARAMS: begin
				if (after_space)
					split_space();
				status = STAT_OK;
			end
			ST_TRAILING: status = STAT_OK;
			default:     status = STAT_NO_COMMAND;
		endcase
		queue_field('0, '0, '0, 1'b0, 1'b0, 1'b1, status);
		clear_line();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_limit   = 5'd16;
			param_limit = 4'd15;
			clear_line();
			parsed_fields.delete();
			fail_count     = 0;
			results_seen   = 0;
			fields_waiting = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TAG_LIMIT)
					tag_limit = cfg_data;
				else
					param_limit = cfg_data[3:0];
			end
			if (push && !full) begin
				if (byte_present && line_byte != 8'h00)
					parse_byte(line_byte);
				if (end_of_line)
					close_line();
			end
			if (pop && !empty) begin
				if (parsed_fields.size() == 0) begin
					report_error($sformatf("result with none waiting: kind %0d byte %02h done %0d",
						field_kind, out_byte, line_done));
				end else begin
					want = parsed_fields.pop_front();
					check_field("field_kind", field_kind, want.kind);
					check_field("field_index", field_index, want.index);
					check_field("out_byte", out_byte, want.data);
					check_field("byte_valid", byte_valid, want.valid);
					check_field("opens_field", opens_field, want.opens);
					check_field("line_done", line_done, want.done);
					check_field("line_status", line_status, want.status);
				end
				results_seen++;
			end
			fields_waiting = parsed_fields.size();
		end
	end

endmodule

// ----- sim/irc_line_field_parser_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for irc_line_field_parser: drives directed and random lines through
// several limit settings and idle patterns, and gives the verdict from ilfp_checker.
// Depends on ilfp_pkg, irc_line_field_parser and ilfp_checker.
module irc_line_field_parser_tb;
	import ilfp_pkg::*;

	typedef enum int {W_PLAIN, W_VALUE, W_CMD, W_TEXT} word_kind_e;
	typedef enum int {LINE_NORMAL, LINE_MANY_TAGS, LINE_MANY_PARAMS, LINE_SPLITS} line_shape_e;

	localparam logic [7:0] PUNCT [10] = '{8'h2D, 8'h2E, 8'h5F, 8'h23, 8'h21, 8'h7E,
		CH_EQ, 8'h60, 8'h7B, CH_AT};
	localparam logic [7:0] ESC_NEXT [8] = '{CH_LS, CH_COLON, CH_LR, CH_LN, CH_BSL,
		8'h78, 8'h71, CH_SEMI};

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [7:0]            line_byte;
	logic                  byte_present;
	logic                  end_of_line;
	logic                  empty;
	logic                  pop;
	logic [2:0]            field_kind;
	logic [3:0]            field_index;
	logic [7:0]            out_byte;
	logic                  byte_valid;
	logic                  opens_field;
	logic                  line_done;
	logic [2:0]            line_status;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                    fail_count;
	int                    fields_waiting;
	int                    send_idle;
	int                    recv_stall;
	int                    items_sent;
	logic [7:0]            line_buf[$];

	irc_line_field_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.line_byte    (line_byte),
		.byte_present (byte_present),
		.end_of_line  (end_of_line),
		.empty        (empty),
		.pop          (pop),
		.field_kind   (field_kind),
		.field_index  (field_index),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.opens_field  (opens_field),
		.line_done    (line_done),
		.line_status  (line_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ilfp_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.line_byte      (line_byte),
		.byte_present   (byte_present),
		.end_of_line    (end_of_line),
		.empty          (empty),
		.pop            (pop),
		.field_kind     (field_kind),
		.field_index    (field_index),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.opens_field    (opens_field),
		.line_done      (line_done),
		.line_status    (line_status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.fields_waiting (fields_waiting)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [7:0] letter();
		logic [7:0] c;
		c = CH_LA + 8'($urandom_range(25));
		if ($urandom_range(1))
			c = c - CASE_OFS;
		return c;
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(3))
			0, 1: return letter();
			2: return 8'h30 + 8'($urandom_range(9));
			default: return PUNCT[$urandom_range(9)];
		endcase
	endfunction

	task automatic add_word(word_kind_e kind, int lo, int hi);
		int n;
		n = $urandom_range(hi, lo);
		for (int i = 0; i < n; i++) begin
			case (kind)
				W_CMD: line_buf.push_back(($urandom_range(7) == 0) ? any_char() : letter());
				W_VALUE: begin
					if ($urandom_range(3) == 0) begin
						line_buf.push_back(CH_BSL);
						line_buf.push_back(ESC_NEXT[$urandom_range(7)]);
					end else begin
						line_buf.push_back(any_char());
					end
				end
				W_TEXT: begin
					case ($urandom_range(7))
						0: line_buf.push_back(CH_SPACE);
						1: line_buf.push_back(CH_COLON);
						default: line_buf.push_back(any_char());
					endcase
				end
				default: line_buf.push_back(any_char());
			endcase
		end
	endtask

	// Mostly well-formed lines with random content; normal lines sometimes get a
	// stray byte of any value or are cut short.
	task automatic make_line(line_shape_e shape);
		int n;
		line_buf.delete();
		if (shape == LINE_MANY_TAGS || (shape == LINE_NORMAL && $urandom_range(2) == 0)) begin
			line_buf.push_back(CH_AT);
			n = (shape == LINE_MANY_TAGS) ? 19 : $urandom_range(4);
			for (int t = 0; t < n; t++) begin
				if (t > 0)
					line_buf.push_back(CH_SEMI);
				if ($urandom_range(5) == 0)
					line_buf.push_back(CH_SEMI);
				add_word(W_PLAIN, (shape == LINE_MANY_TAGS) ? 1 : 0, 3);
				if ($urandom_range(1)) begin
					line_buf.push_back(CH_EQ);
					add_word(W_VALUE, 0, 4);
					if ($urandom_range(5) == 0)
						line_buf.push_back(CH_BSL);
				end
			end
			line_buf.push_back(CH_SPACE);
		end
		if ($urandom_range(3) == 0) begin
			line_buf.push_back(CH_COLON);
			add_word(W_PLAIN, 0, 4);
			line_buf.push_back(CH_SPACE);
		end
		add_word(W_CMD, 1, 5);
		if (shape == LINE_SPLITS) begin
			repeat (305) line_buf.push_back(CH_SPACE);
			n = 3;
		end else begin
			n = (shape == LINE_MANY_PARAMS) ? 17 : $urandom_range(4);
		end
		for (int p = 0; p < n; p++) begin
			repeat ($urandom_range(3, 1)) line_buf.push_back(CH_SPACE);
			add_word(W_PLAIN, 1, (shape == LINE_MANY_PARAMS) ? 1 : 4);
		end
		if ($urandom_range(1)) begin
			line_buf.push_back(CH_SPACE);
			line_buf.push_back(CH_COLON);
			add_word(W_TEXT, 0, 6);
		end else if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(2, 1)) line_buf.push_back(CH_SPACE);
		end
		if (shape == LINE_NORMAL) begin
			if ($urandom_range(4) == 0)
				line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(line_buf.size());
				while (line_buf.size() > n)
					void'(line_buf.pop_back());
			end
		end
	endtask

	// Called and returning at a falling edge; push stays high for the next item.
	task automatic send_item(logic [7:0] b, logic present, logic eol);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		line_byte    <= b;
		byte_present <= present;
		end_of_line  <= eol;
		do @(posedge clk); while (full);
		@(negedge clk);
		if ((present && b != 8'h00) || eol)
			items_sent++;
	endtask

	task automatic send_line();
		int   n;
		logic bare_end;
		n = line_buf.size();
		bare_end = (n == 0) || ($urandom_range(5) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(line_buf[i], 1'b1, !bare_end && i == n - 1);
		end
		if (bare_end)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Lines with no results may still be in flight, so allow some cycles after the
	// last expected result.
	task automatic drain();
		push <= 1'b0;
		while (fields_waiting != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	initial begin
		pop <= 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		int goal;
		arst_n       = 1'b0;
		push         = 1'b0;
		line_byte    = '0;
		byte_present = 1'b0;
		end_of_line  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TAG_LIMIT;
		cfg_data     = '0;
		send_idle    = 0;
		recv_stall   = 0;
		items_sent   = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(CH_AT, 1'b1, 1'b0);
		send_item(CH_LA, 1'b1, 1'b0);
		send_item(CH_EQ, 1'b1, 1'b0);
		send_item(CH_BSL, 1'b1, 1'b1);
		send_item(CH_AT, 1'b1, 1'b0);
		send_item(8'h78, 1'b1, 1'b0);
		send_item(CH_EQ, 1'b1, 1'b0);
		send_item(CH_BSL, 1'b1, 1'b0);
		send_item(CH_SPACE, 1'b1, 1'b0);
		send_item(CH_LA, 1'b1, 1'b1);
		send_item(CH_COLON, 1'b1, 1'b0);
		send_item(CH_LZ, 1'b1, 1'b1);
		send_item(CH_SPACE, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(CH_LA, 1'b1, 1'b1);
		send_item(CH_LZ, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(CH_SPACE, 1'b1, 1'b0);
		send_item(CH_COLON, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0, 7: begin
					write_reg(CFG_TAG_LIMIT, 5'd16);
					write_reg(CFG_PARAM_LIMIT, 5'd15);
				end
				1: begin
					write_reg(CFG_TAG_LIMIT, 5'd0);
					write_reg(CFG_PARAM_LIMIT, 5'd0);
				end
				2: begin
					write_reg(CFG_TAG_LIMIT, 5'd1);
					write_reg(CFG_PARAM_LIMIT, 5'd1);
				end
				3: begin
					write_reg(CFG_TAG_LIMIT, 5'd31);
					write_reg(CFG_PARAM_LIMIT, 5'd31);
				end
				4: begin
					write_reg(CFG_TAG_LIMIT, 5'd2);
					write_reg(CFG_PARAM_LIMIT, 5'd3);
				end
				5: begin
					write_reg(CFG_TAG_LIMIT, 5'd17);
					write_reg(CFG_PARAM_LIMIT, 5'd14);
				end
				default: begin
					write_reg(CFG_TAG_LIMIT, 5'($urandom_range(31)));
					write_reg(CFG_PARAM_LIMIT, 5'($urandom_range(31)));
				end
			endcase
			case (ph % 4)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle  = 66;
					recv_stall = 0;
				end
				2: begin
					send_idle  = 0;
					recv_stall = 66;
				end
				default: begin
					send_idle  = 16;
					recv_stall = 16;
				end
			endcase
			goal = items_sent + 20;
			if (ph == 0 || ph == 3) begin
				make_line(LINE_MANY_TAGS);
				send_line();
				make_line(LINE_MANY_PARAMS);
				send_line();
			end
			if (ph == 7) begin
				make_line(LINE_SPLITS);
				send_line();
			end
			while (items_sent < goal) begin
				make_line(LINE_NORMAL);
				send_line();
			end
		end

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("ERROR: run did not finish in time, %0d results outstanding", fields_waiting);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ilfp_pkg.sv
rtl/core/ilfp_front.sv
rtl/core/ilfp_queue.sv
rtl/core/ilfp_back.sv
rtl/core/irc_line_field_parser.sv
sim/ilfp_checker.sv
sim/irc_line_field_parser_tb.sv
